>>> src/abc_pkg.sv
// shared constants and types for the box relation classifier
`timescale 1ns / 1ps

package abc_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int TOL_W           = 16;
    localparam int CFG_IDX_W       = 3;
    localparam int AXES            = 3;

    localparam logic [TOL_W-1:0] TOL_RESET = 16'd7;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_Z = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TOL   = 3'd6;

    // query kinds
    localparam logic [1:0] FUNC_POINT = 2'd0;
    localparam logic [1:0] FUNC_PLANE = 2'd1;
    localparam logic [1:0] FUNC_BOX   = 2'd2;
    localparam logic [1:0] FUNC_NONE  = 2'd3;

    // relation codes
    localparam logic [1:0] REL_OUTSIDE  = 2'd0;
    localparam logic [1:0] REL_INSIDE   = 2'd1;
    localparam logic [1:0] REL_ON       = 2'd2;
    localparam logic [1:0] REL_FRONT    = 2'd0;
    localparam logic [1:0] REL_BACK     = 2'd1;
    localparam logic [1:0] REL_STRADDLE = 2'd2;
    localparam logic [1:0] REL_DISJOINT = 2'd0;
    localparam logic [1:0] REL_OVERLAP  = 2'd1;

    typedef struct packed {
        logic beyond_tol;   // point past the surface by more than the tolerance
        logic within_tol;   // point inside the surface by more than the tolerance
        logic separated;    // query box apart from the box on this axis
    } axis_flags_t;

endpackage

>>> src/abc_cfg_regs.sv
// box corner and tolerance configuration registers
`timescale 1ns / 1ps

module abc_cfg_regs #(
    parameter int COORD_WIDTH = abc_pkg::COORD_WIDTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    input  logic [abc_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [COORD_WIDTH-1:0]                 cfg_data,
    output logic signed [COORD_WIDTH-1:0]          box_min [abc_pkg::AXES],
    output logic signed [COORD_WIDTH-1:0]          box_max [abc_pkg::AXES],
    output logic [abc_pkg::TOL_W-1:0]              tol
);
    import abc_pkg::*;

    logic signed [COORD_WIDTH-1:0] min_reg [AXES];
    logic signed [COORD_WIDTH-1:0] max_reg [AXES];
    logic [TOL_W-1:0]              tol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                min_reg[i] <= '0;
                max_reg[i] <= '0;
            end
            tol_reg <= TOL_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MIN_X: min_reg[0] <= $signed(cfg_data);
                CFG_MIN_Y: min_reg[1] <= $signed(cfg_data);
                CFG_MIN_Z: min_reg[2] <= $signed(cfg_data);
                CFG_MAX_X: max_reg[0] <= $signed(cfg_data);
                CFG_MAX_Y: max_reg[1] <= $signed(cfg_data);
                CFG_MAX_Z: max_reg[2] <= $signed(cfg_data);
                CFG_TOL:   tol_reg    <= cfg_data[TOL_W-1:0];
                default:   ;
            endcase
        end
    end

    assign box_min = min_reg;
    assign box_max = max_reg;
    assign tol     = tol_reg;

endmodule

>>> src/abc_axis_eval.sv
// per-axis point, box and plane-corner evaluation
`timescale 1ns / 1ps

module abc_axis_eval #(
    parameter int COORD_WIDTH = abc_pkg::COORD_WIDTH_DEF
) (
    input  logic signed [COORD_WIDTH-1:0]   box_lo,
    input  logic signed [COORD_WIDTH-1:0]   box_hi,
    input  logic [abc_pkg::TOL_W-1:0]       tol,
    input  logic signed [COORD_WIDTH-1:0]   vec,
    input  logic signed [COORD_WIDTH-1:0]   other_lo,
    input  logic signed [COORD_WIDTH-1:0]   other_hi,
    output abc_pkg::axis_flags_t            flags,
    output logic signed [COORD_WIDTH-1:0]   near_corner,
    output logic signed [COORD_WIDTH-1:0]   far_corner
);
    import abc_pkg::*;

    // doubled values: 2p - (lo + hi) and hi - lo need three extra bits
    localparam int DW = COORD_WIDTH + 3;

    logic signed [DW-1:0] p_e;
    logic signed [DW-1:0] lo_e;
    logic signed [DW-1:0] hi_e;
    logic signed [DW-1:0] centre_off;
    logic signed [DW-1:0] centre_abs;
    logic signed [DW-1:0] axis_gap;
    logic signed [DW-1:0] tol2;

    always_comb
    begin
        p_e        = {{3{vec[COORD_WIDTH-1]}}, vec};
        lo_e       = {{3{box_lo[COORD_WIDTH-1]}}, box_lo};
        hi_e       = {{3{box_hi[COORD_WIDTH-1]}}, box_hi};
        centre_off = (p_e <<< 1) - (lo_e + hi_e);
        centre_abs = centre_off[DW-1] ? -centre_off : centre_off;
        axis_gap   = centre_abs - (hi_e - lo_e);
        tol2       = $signed({{(DW-TOL_W-1){1'b0}}, tol, 1'b0});

        flags.beyond_tol = axis_gap > tol2;
        flags.within_tol = axis_gap < -tol2;
        flags.separated  = (box_lo > other_hi) || (other_lo > box_hi);

        // a negative normal component takes the max corner as near
        if (vec[COORD_WIDTH-1])
        begin
            near_corner = box_hi;
            far_corner  = box_lo;
        end
        else
        begin
            near_corner = box_lo;
            far_corner  = box_hi;
        end
    end

endmodule

>>> src/abc_plane_sum.sv
// plane dot-product sums and front / back / straddle decision
`timescale 1ns / 1ps

module abc_plane_sum #(
    parameter int COORD_WIDTH = abc_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = abc_pkg::FRAC_BITS_DEF
) (
    input  logic signed [2*COORD_WIDTH-1:0] near_prod [abc_pkg::AXES],
    input  logic signed [2*COORD_WIDTH-1:0] far_prod  [abc_pkg::AXES],
    input  logic signed [COORD_WIDTH-1:0]   offset,
    output logic [1:0]                      plane_rel
);
    import abc_pkg::*;

    localparam int PW = 2 * COORD_WIDTH;
    localparam int OW = COORD_WIDTH + FRAC_BITS;
    localparam int SW = ((PW > OW) ? PW : OW) + 3;

    logic signed [SW-1:0] off_e;
    logic signed [SW-1:0] near_sum;
    logic signed [SW-1:0] far_sum;

    always_comb
    begin
        // offset moved to the product scale
        off_e    = $signed({{(SW-COORD_WIDTH){offset[COORD_WIDTH-1]}}, offset}) <<< FRAC_BITS;
        near_sum = off_e;
        far_sum  = off_e;
        for (int i = 0; i < AXES; i++)
        begin
            near_sum = near_sum + $signed({{(SW-PW){near_prod[i][PW-1]}}, near_prod[i]});
            far_sum  = far_sum + $signed({{(SW-PW){far_prod[i][PW-1]}}, far_prod[i]});
        end

        if (!near_sum[SW-1] && (near_sum != '0))
            plane_rel = REL_FRONT;
        else if (far_sum[SW-1])
            plane_rel = REL_BACK;
        else
            plane_rel = REL_STRADDLE;
    end

endmodule

>>> src/aabb_relation_classifier.sv
// top level of the axis-aligned box relation classifier
`timescale 1ns / 1ps

// Classifies a point, a plane or a second box against the configured box and
// returns one relation code per query together with an echo of the query
// kind. Queries are accepted one per clock while ready is high; each passes an
// input register, a product register holding the six plane products (normal
// component times near and far corner) and a result register, which offers
// the result word. The plane path sets that depth: the signed multipliers
// feed the product register, and the four-term sums and sign tests feed the
// result register. Point and box tests finish in the first stage and ride
// along. Ready is withdrawn only when all three stages hold words and the
// result is not being taken. Configuration writes are always ready and take
// effect on the following cycle.

module aabb_relation_classifier #(
    parameter int COORD_WIDTH = abc_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = abc_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [abc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [COORD_WIDTH-1:0]            cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        func,
    input  logic signed [COORD_WIDTH-1:0]     vec_x,
    input  logic signed [COORD_WIDTH-1:0]     vec_y,
    input  logic signed [COORD_WIDTH-1:0]     vec_z,
    input  logic signed [COORD_WIDTH-1:0]     plane_offset,
    input  logic signed [COORD_WIDTH-1:0]     other_min_x,
    input  logic signed [COORD_WIDTH-1:0]     other_min_y,
    input  logic signed [COORD_WIDTH-1:0]     other_min_z,
    input  logic signed [COORD_WIDTH-1:0]     other_max_x,
    input  logic signed [COORD_WIDTH-1:0]     other_max_y,
    input  logic signed [COORD_WIDTH-1:0]     other_max_z,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [1:0]                        relation,
    output logic [1:0]                        query_kind
);
    import abc_pkg::*;

    localparam int PW = 2 * COORD_WIDTH;

    logic signed [COORD_WIDTH-1:0] box_min [AXES];
    logic signed [COORD_WIDTH-1:0] box_max [AXES];
    logic [TOL_W-1:0]              tol;

    // stage 1: input register
    logic                          v1_reg;
    logic [1:0]                    func1_reg;
    logic signed [COORD_WIDTH-1:0] vec1_reg  [AXES];
    logic signed [COORD_WIDTH-1:0] omin1_reg [AXES];
    logic signed [COORD_WIDTH-1:0] omax1_reg [AXES];
    logic signed [COORD_WIDTH-1:0] off1_reg;
    logic signed [COORD_WIDTH-1:0] vec1_next  [AXES];
    logic signed [COORD_WIDTH-1:0] omin1_next [AXES];
    logic signed [COORD_WIDTH-1:0] omax1_next [AXES];

    // stage 2: product register
    logic                          v2_reg;
    logic [1:0]                    func2_reg;
    logic [1:0]                    rel2_reg;
    logic [1:0]                    rel2_next;
    logic signed [PW-1:0]          near_p_reg  [AXES];
    logic signed [PW-1:0]          far_p_reg   [AXES];
    logic signed [PW-1:0]          near_p_next [AXES];
    logic signed [PW-1:0]          far_p_next  [AXES];
    logic signed [COORD_WIDTH-1:0] off2_reg;

    // stage 3: result register
    logic                          v3_reg;
    logic [1:0]                    rel3_reg;
    logic [1:0]                    kind3_reg;
    logic [1:0]                    rel3_next;
    logic [1:0]                    plane_rel;

    axis_flags_t                   flags  [AXES];
    logic signed [COORD_WIDTH-1:0] near_c [AXES];
    logic signed [COORD_WIDTH-1:0] far_c  [AXES];

    logic adv1;
    logic adv2;
    logic adv3;
    logic any_beyond;
    logic any_within;
    logic any_sep;

    assign cfg_ready = 1'b1;

    abc_cfg_regs #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .box_min   (box_min),
        .box_max   (box_max),
        .tol       (tol)
    );

    // each stage moves when the one after it is empty or moving
    assign adv3     = !v3_reg || out_ready;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    assign vec1_next[0]  = vec_x;
    assign vec1_next[1]  = vec_y;
    assign vec1_next[2]  = vec_z;
    assign omin1_next[0] = other_min_x;
    assign omin1_next[1] = other_min_y;
    assign omin1_next[2] = other_min_z;
    assign omax1_next[0] = other_max_x;
    assign omax1_next[1] = other_max_y;
    assign omax1_next[2] = other_max_z;

    for (genvar g = 0; g < AXES; g++)
    begin : g_axis
        abc_axis_eval #(
            .COORD_WIDTH (COORD_WIDTH)
        ) u_axis (
            .box_lo      (box_min[g]),
            .box_hi      (box_max[g]),
            .tol         (tol),
            .vec         (vec1_reg[g]),
            .other_lo    (omin1_reg[g]),
            .other_hi    (omax1_reg[g]),
            .flags       (flags[g]),
            .near_corner (near_c[g]),
            .far_corner  (far_c[g])
        );

        assign near_p_next[g] = PW'(vec1_reg[g]) * PW'(near_c[g]);
        assign far_p_next[g]  = PW'(vec1_reg[g]) * PW'(far_c[g]);
    end

    always_comb
    begin
        any_beyond = 1'b0;
        any_within = 1'b0;
        any_sep    = 1'b0;
        for (int i = 0; i < AXES; i++)
        begin
            any_beyond = any_beyond | flags[i].beyond_tol;
            any_within = any_within | flags[i].within_tol;
            any_sep    = any_sep | flags[i].separated;
        end

        case (func1_reg)
            FUNC_POINT:
            begin
                if (any_beyond)
                    rel2_next = REL_OUTSIDE;
                else if (any_within)
                    rel2_next = REL_INSIDE;
                else
                    rel2_next = REL_ON;
            end
            FUNC_BOX: rel2_next = any_sep ? REL_DISJOINT : REL_OVERLAP;
            default:  rel2_next = REL_OUTSIDE;
        endcase
    end

    abc_plane_sum #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_plane (
        .near_prod (near_p_reg),
        .far_prod  (far_p_reg),
        .offset    (off2_reg),
        .plane_rel (plane_rel)
    );

    assign rel3_next = (func2_reg == FUNC_PLANE) ? plane_rel : rel2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                v1_reg <= in_valid;
            if (adv2)
                v2_reg <= v1_reg;
            if (adv3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && in_valid)
        begin
            func1_reg <= func;
            off1_reg  <= plane_offset;
            vec1_reg  <= vec1_next;
            omin1_reg <= omin1_next;
            omax1_reg <= omax1_next;
        end
        if (adv2 && v1_reg)
        begin
            func2_reg  <= func1_reg;
            rel2_reg   <= rel2_next;
            off2_reg   <= off1_reg;
            near_p_reg <= near_p_next;
            far_p_reg  <= far_p_next;
        end
        if (adv3 && v2_reg)
        begin
            rel3_reg  <= rel3_next;
            kind3_reg <= func2_reg;
        end
    end

    assign out_valid  = v3_reg;
    assign relation   = rel3_reg;
    assign query_kind = kind3_reg;

endmodule

>>> src/abc_port_checker.sv
// port-level checks for the box relation classifier, bound to the top level
`timescale 1ns / 1ps

module abc_port_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] relation,
    input logic [1:0] query_kind
);
    import abc_pkg::*;

    // a held result word keeps its contents
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(relation) && $stable(query_kind))
    else $error("held result word changed");

    // input back-pressure only when a full pipe meets a stalled output
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
    else $error("input stalled while output free");

    // box queries only give disjoint or overlap
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && query_kind == FUNC_BOX |->
            relation == REL_DISJOINT || relation == REL_OVERLAP)
    else $error("bad box relation");

    // unused query kind reports zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && query_kind == FUNC_NONE |-> relation == REL_OUTSIDE)
    else $error("unused query kind gave a relation");

    // no query kind yields code three
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> relation != 2'd3)
    else $error("relation code out of range");

endmodule

bind aabb_relation_classifier abc_port_checker u_abc_port_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .relation   (relation),
    .query_kind (query_kind)
);
